@@ sv/mldb_pkg.sv @@
package mldb_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_SCAN   = 3'd0,
    OP_DIGIT  = 3'd1,
    OP_POINT  = 3'd2,
    OP_BIT    = 3'd3,
    OP_NUMBER = 3'd4
  } op_e;

  localparam int unsigned WordW = 16;
  localparam int unsigned BcdDigits = 6;
  localparam int unsigned NumW = 17;

  localparam logic [WordW-1:0] BlankWord = 16'hFFFF;
  localparam logic [3:0] PointBit = 4'd10;
  localparam logic [3:0] DigitReject = 4'd15;

  // Number fields: start word and digit count
  localparam logic [3:0] Field0Start = 4'd0;
  localparam logic [3:0] Field1Start = 4'd3;
  localparam logic [2:0] Field0Width = 3'd3;
  localparam logic [2:0] Field1Width = 3'd5;

  // Segment code for a digit code, active low
  function automatic logic [WordW-1:0] seg_code(input logic [3:0] code);
    logic [WordW-1:0] w;
    case (code)
      4'd0:    w = 16'h3E7C;
      4'd1:    w = 16'h7FFE;
      4'd2:    w = 16'h3D7D;
      4'd3:    w = 16'h3DFC;
      4'd4:    w = 16'h7CFE;
      4'd5:    w = 16'hBCFC;
      4'd6:    w = 16'hBC7C;
      4'd7:    w = 16'h3FFE;
      4'd8:    w = 16'h3C7C;
      4'd9:    w = 16'h3CFC;
      4'd10:   w = 16'h3C7E;
      4'd11:   w = 16'hFC7C;
      4'd12:   w = 16'hBE7D;
      4'd13:   w = 16'h7D7C;
      4'd14:   w = 16'hBC7D;
      default: w = BlankWord;
    endcase
    return w;
  endfunction

endpackage

@@ sv/multiplexed_led_display_buffer.sv @@
// Frame store for a multiplexed seven-segment display with a scan pointer.
// Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
// scan tick, digit write, point bit, word bit or decimal number write.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// item; only a scan tick carries a word, only a rejected digit flags error.
// The display words sit in a 16-bit wide synchronous RAM with a registered
// read; writes of untouched entries are tracked by a valid bit per word.
// Items are handled one at a time by a small sequencer; steps per item:
//   digit write, unused codes, bit operation on a missing word : no RAM read
//   scan tick : RAM read, then the word is emitted
//   bit operations : RAM read, then modify and write back
//   number write : division by ten into six decimal digits, one per step,
//                  then one write per field word
// A result is valid in the cycle after its item leaves the sequencer.
// The next item is taken as soon as the sequencer is back to idle, even
// while the previous result still waits in the output register.
// Reset clears the valid bits (every word reads as 0xFFFF, all segments
// off), the scan pointer and the output register at once; no clearing pass.
// A stalled result holds its payload; a finished item then waits for the
// output register before the next item is taken.
module multiplexed_led_display_buffer
  import mldb_pkg::*;
#(
  parameter int unsigned DISPLAY_WORDS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           op_i,
  input  logic [3:0]           position_i,
  input  logic [3:0]           digit_i,
  input  logic [3:0]           bit_offset_i,
  input  logic                 bit_value_i,
  input  logic                 field_select_i,
  input  logic [NumW-1:0]      number_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 scan_valid_o,
  output logic [3:0]           scan_position_o,
  output logic [WordW-1:0]     scan_word_o,
  output logic                 error_o
);

  localparam int unsigned AW = (DISPLAY_WORDS > 2) ? $clog2(DISPLAY_WORDS) : 1;
  localparam logic [4:0] WordsLim = 5'(DISPLAY_WORDS);
  localparam logic [AW-1:0] LastIdx = AW'(DISPLAY_WORDS - 1);
  localparam logic [4:0] ConvLast = 5'(BcdDigits - 1);
  // Reciprocal of ten, exact for every 17-bit value after the shift
  localparam logic [NumW-1:0] Recip10 = 17'd104858;
  localparam int unsigned RecipShift = 20;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CONV = 5'b00100,
    S_NUM  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Frame RAM and per-word written flags
  logic [WordW-1:0]         mem_q [DISPLAY_WORDS];
  logic [DISPLAY_WORDS-1:0] vld_q, vld_d;
  logic [WordW-1:0]         rd_data_q;
  logic                     rd_vld_q;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [WordW-1:0]         wr_data;

  // Held item and working registers
  logic [AW-1:0]      ptr_q, ptr_d;
  op_e                op_q, op_d;
  logic [3:0]         pos_q, pos_d;
  logic [3:0]         boff_q, boff_d;
  logic               bval_q, bval_d;
  logic               fsel_q, fsel_d;
  logic [NumW-1:0]    bin_q, bin_d;
  logic [4*BcdDigits-1:0] bcd_q, bcd_d;
  logic [4:0]         cnt_q, cnt_d;

  // Pending result and output register
  logic               res_scan_q, res_scan_d;
  logic [3:0]         res_pos_q, res_pos_d;
  logic [WordW-1:0]   res_word_q, res_word_d;
  logic               res_err_q, res_err_d;
  logic               out_valid_q, out_valid_d;
  logic               out_scan_q;
  logic [3:0]         out_pos_q;
  logic [WordW-1:0]   out_word_q;
  logic               out_err_q;
  logic               out_load;

  // Combinational helpers
  logic               accept;
  op_e                op_in;
  logic               pos_in_ok;
  logic               pos_q_ok;
  logic [WordW-1:0]   cur_word;
  logic [WordW-1:0]   sel_mask;
  logic [3:0]         bit_idx;
  logic [2*NumW-1:0]  quot_prod;
  logic [NumW-1:0]    quot;
  logic [3:0]         rem_digit;
  logic [2:0]         ndig;
  logic [2:0]         fwidth;
  logic [3:0]         fstart;
  logic [2:0]         dshift;
  logic [2:0]         didx;
  logic [3:0]         dcode;
  logic [3:0]         naddr;

  assign op_in      = op_e'(op_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign pos_in_ok  = ({1'b0, position_i} < WordsLim);
  assign pos_q_ok   = ({1'b0, pos_q} < WordsLim);
  assign cur_word   = rd_vld_q ? rd_data_q : BlankWord;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Divide by ten: reciprocal multiply for the quotient, then the remainder
  assign quot_prod = bin_q * Recip10;
  assign quot      = NumW'(quot_prod >> RecipShift);
  assign rem_digit = 4'(bin_q - ((quot << 3) + (quot << 1)));

  // Count significant decimal digits, at least one
  always_comb begin
    ndig = 3'd1;
    for (int k = BcdDigits - 1; k >= 1; k--) begin
      if (ndig == 3'd1 && bcd_q[4*k +: 4] != 4'd0) begin
        ndig = 3'(k + 1);
      end
    end
  end

  // Pick the field digit for the current write: leading digits win
  always_comb begin
    fwidth = fsel_q ? Field1Width : Field0Width;
    fstart = fsel_q ? Field1Start : Field0Start;
    dshift = (ndig > fwidth) ? ndig - fwidth : 3'd0;
    didx   = fwidth - 3'd1 - cnt_q[2:0] + dshift;
    dcode  = bcd_q[4*didx +: 4];
    naddr  = fstart + {1'b0, cnt_q[2:0]};
  end

  assign bit_idx  = (op_q == OP_POINT) ? PointBit : boff_q;
  assign sel_mask = WordW'(1) << bit_idx;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    op_d       = op_q;
    pos_d      = pos_q;
    boff_d     = boff_q;
    bval_d     = bval_q;
    fsel_d     = fsel_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    cnt_d      = cnt_q;
    res_scan_d = res_scan_q;
    res_pos_d  = res_pos_q;
    res_word_d = res_word_q;
    res_err_d  = res_err_q;
    rd_en      = 1'b0;
    rd_addr    = ptr_q;
    wr_en      = 1'b0;
    wr_addr    = position_i[AW-1:0];
    wr_data    = seg_code(digit_i);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d       = op_in;
          pos_d      = position_i;
          boff_d     = bit_offset_i;
          bval_d     = bit_value_i;
          fsel_d     = field_select_i;
          res_scan_d = 1'b0;
          res_pos_d  = 4'd0;
          res_word_d = '0;
          res_err_d  = 1'b0;
          state_d    = S_DONE;
          unique case (op_in) inside
            OP_SCAN: begin
              rd_en   = 1'b1;
              rd_addr = ptr_q;
              state_d = S_RD;
            end
            OP_DIGIT: begin
              if (digit_i == DigitReject) begin
                res_err_d = 1'b1;
              end else begin
                wr_en = pos_in_ok;
              end
            end
            OP_POINT, OP_BIT: begin
              if (pos_in_ok) begin
                rd_en   = 1'b1;
                rd_addr = position_i[AW-1:0];
                state_d = S_RD;
              end
            end
            OP_NUMBER: begin
              bin_d   = number_value_i;
              bcd_d   = '0;
              cnt_d   = 5'd0;
              state_d = S_CONV;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        // Emit the scanned word, or modify one bit and write back
        if (op_q == OP_SCAN) begin
          res_scan_d = 1'b1;
          res_pos_d  = 4'(ptr_q);
          res_word_d = cur_word;
          ptr_d      = (ptr_q == LastIdx) ? '0 : ptr_q + AW'(1);
        end else begin
          wr_en   = pos_q_ok;
          wr_addr = pos_q[AW-1:0];
          wr_data = bval_q ? (cur_word | sel_mask) : (cur_word & ~sel_mask);
        end
        state_d = S_DONE;
      end
      S_CONV: begin
        // One decimal digit per cycle, least significant first
        bcd_d = {rem_digit, bcd_q[4*BcdDigits-1:4]};
        bin_d = quot;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == ConvLast) begin
          cnt_d   = 5'd0;
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        // One field word per cycle, most significant first
        wr_en   = ({1'b0, naddr} < WordsLim);
        wr_addr = naddr[AW-1:0];
        wr_data = seg_code(dcode);
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q[2:0] == fwidth - 3'd1) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Mark words once written
  always_comb begin
    vld_d = vld_q;
    if (wr_en) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  // Output register: load a finished result, drop it on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Frame RAM write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= 5'd0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_q      <= pos_d;
    boff_q     <= boff_d;
    bval_q     <= bval_d;
    fsel_q     <= fsel_d;
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    res_scan_q <= res_scan_d;
    res_pos_q  <= res_pos_d;
    res_word_q <= res_word_d;
    res_err_q  <= res_err_d;
    if (out_load) begin
      out_scan_q <= res_scan_q;
      out_pos_q  <= res_pos_q;
      out_word_q <= res_word_q;
      out_err_q  <= res_err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scan_valid_o    = out_scan_q;
  assign scan_position_o = out_pos_q;
  assign scan_word_o     = out_word_q;
  assign error_o         = out_err_q;

endmodule

@@ sv/mldb_checker.sv @@
module mldb_checker
  import mldb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              scan_valid_o,
  input logic [3:0]        scan_position_o,
  input logic [WordW-1:0]  scan_word_o,
  input logic              error_o
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(scan_valid_o)
      && $stable(scan_position_o) && $stable(scan_word_o) && $stable(error_o))
    else $error("stalled result changed");

  // A result that is no scan carries no word and no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !scan_valid_o |-> scan_position_o == 4'd0 && scan_word_o == '0)
    else $error("non-scan result carries a word");

  // Error and scan never come together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !scan_valid_o)
    else $error("error flagged on a scan result");

  // One item at a time: the input stalls right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

endmodule

bind multiplexed_led_display_buffer mldb_checker u_mldb_checker (.*);

@@ verif/tb_top.sv @@
module tb_top;
  import mldb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Spare operation codes: no effect, all-zero result
  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast  = 3'd7;

  localparam int unsigned Words         = 16;
  localparam int unsigned IdlePct       = 21;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomItems   = 800;
  localparam int unsigned MaxPrinted    = 60;

  // Active-low segment glyphs for digit codes 0 to 14
  localparam logic [WordW-1:0] SegGlyphs [15] = '{
    16'h3E7C, 16'h7FFE, 16'h3D7D, 16'h3DFC, 16'h7CFE, 16'hBCFC, 16'hBC7C, 16'h3FFE,
    16'h3C7C, 16'h3CFC, 16'h3C7E, 16'hFC7C, 16'hBE7D, 16'h7D7C, 16'hBC7D
  };

  typedef struct packed {
    logic [2:0]      op;
    logic [3:0]      position;
    logic [3:0]      digit;
    logic [3:0]      bit_offset;
    logic            bit_value;
    logic            field_select;
    logic [NumW-1:0] number;
  } disp_item_t;

  typedef struct packed {
    logic             scan_valid;
    logic [3:0]       scan_position;
    logic [WordW-1:0] scan_word;
    logic             error;
  } disp_result_t;

  typedef struct {
    disp_item_t   item;
    bit           fixed;
    disp_result_t want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        op = OP_SCAN;
  logic [3:0]        position = '0;
  logic [3:0]        digit = '0;
  logic [3:0]        bit_offset = '0;
  logic              bit_value = 1'b0;
  logic              field_select = 1'b0;
  logic [NumW-1:0]   number_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              scan_valid;
  logic [3:0]        scan_position;
  logic [WordW-1:0]  scan_word;
  logic              error;

  // Shadow display state
  logic [WordW-1:0]  frame_shadow [Words];
  logic [3:0]        scan_ptr_shadow;

  disp_result_t      pending_results [$];
  plan_row_t         directed_plan [$];
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       hold_left = 0;
  bit                hold_req = 1'b0;
  bit                calm = 1'b0;

  multiplexed_led_display_buffer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .position_i     (position),
    .digit_i        (digit),
    .bit_offset_i   (bit_offset),
    .bit_value_i    (bit_value),
    .field_select_i (field_select),
    .number_value_i (number_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .scan_valid_o   (scan_valid),
    .scan_position_o(scan_position),
    .scan_word_o    (scan_word),
    .error_o        (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one item and advance the shadow state
  function automatic disp_result_t display_predict(input disp_item_t it);
    disp_result_t r;
    int unsigned  dig [8];
    int unsigned  n;
    int unsigned  width;
    int unsigned  first;
    int unsigned  v;
    r = '0;
    case (it.op)
      OP_SCAN: begin
        r.scan_valid    = 1'b1;
        r.scan_position = scan_ptr_shadow;
        r.scan_word     = frame_shadow[scan_ptr_shadow];
        scan_ptr_shadow = scan_ptr_shadow + 4'd1;
      end
      OP_DIGIT: begin
        if (it.digit == DigitReject) r.error = 1'b1;
        else frame_shadow[it.position] = SegGlyphs[it.digit];
      end
      OP_POINT: frame_shadow[it.position][PointBit] = it.bit_value;
      OP_BIT:   frame_shadow[it.position][it.bit_offset] = it.bit_value;
      OP_NUMBER: begin
        width = 32'(it.field_select ? Field1Width : Field0Width);
        first = 32'(it.field_select ? Field1Start : Field0Start);
        v = 32'(it.number);
        n = 0;
        // Split into decimal digits, least significant first
        do begin
          dig[n] = v % 10;
          v = v / 10;
          n++;
        end while (v != 0 && n < 8);
        while (n < width) begin
          dig[n] = 0;
          n++;
        end
        // Leading digits go to the field, most significant first
        for (int unsigned i = 0; i < width; i++)
          frame_shadow[first + i] = SegGlyphs[dig[n - 1 - i]];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic disp_item_t make_item(input logic [2:0] o, input int unsigned pos,
                                           input int unsigned dg, input int unsigned off,
                                           input bit val, input bit fsel,
                                           input int unsigned num);
    disp_item_t it;
    it.op           = o;
    it.position     = pos[3:0];
    it.digit        = dg[3:0];
    it.bit_offset   = off[3:0];
    it.bit_value    = val;
    it.field_select = fsel;
    it.number       = num[NumW-1:0];
    return it;
  endfunction

  function automatic disp_item_t random_item();
    int unsigned pick;
    int unsigned num;
    logic [2:0]  o;
    pick = $urandom_range(0, 99);
    if (pick < 34)      o = OP_SCAN;
    else if (pick < 50) o = OP_DIGIT;
    else if (pick < 60) o = OP_POINT;
    else if (pick < 75) o = OP_BIT;
    else if (pick < 94) o = OP_NUMBER;
    else                o = 3'($urandom_range(OpSpareFirst, OpSpareLast));
    // Mostly short numbers, some filling the wide field, some at full width
    pick = $urandom_range(0, 3);
    if (pick < 2)       num = $urandom_range(0, 999);
    else if (pick == 2) num = $urandom_range(0, 99999);
    else                num = $urandom_range(0, (1 << NumW) - 1);
    return make_item(o, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), 1'($urandom), 1'($urandom), num);
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // Offer one item at a falling edge, hold it until the transfer
  task automatic offer(input disp_item_t it, input bit fixed, input disp_result_t want);
    disp_result_t p;
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= it.op;
    position     <= it.position;
    digit        <= it.digit;
    bit_offset   <= it.bit_offset;
    bit_value    <= it.bit_value;
    field_select <= it.field_select;
    number_value <= it.number;
    do @(posedge clk); while (in_stall);
    p = display_predict(it);
    pending_results.push_back(fixed ? want : p);
    @(negedge clk);
  endtask

  // Receiver: random stall, calm stretch, and one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldOffCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    disp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing expected", scan_word, 0);
      end else begin
        want = pending_results.pop_front();
        if (scan_valid !== want.scan_valid)
          note_mismatch("scan_valid", scan_valid, want.scan_valid);
        if (scan_position !== want.scan_position)
          note_mismatch("scan_position", scan_position, want.scan_position);
        if (scan_word !== want.scan_word)
          note_mismatch("scan_word", scan_word, want.scan_word);
        if (error !== want.error)
          note_mismatch("error", error, want.error);
      end
    end
  end

  // Abort when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    disp_result_t none;
    disp_result_t blank_scan;
    disp_result_t rejected;
    none = '0;
    blank_scan = '{scan_valid: 1'b1, scan_position: 4'd0, scan_word: BlankWord, error: 1'b0};
    rejected = '{scan_valid: 1'b0, scan_position: 4'd0, scan_word: '0, error: 1'b1};
    for (int i = 0; i < Words; i++) frame_shadow[i] = BlankWord;
    scan_ptr_shadow = '0;

    // Directed rows: typed results only where obvious
    directed_plan.push_back('{make_item(OP_SCAN, 0, 0, 0, 0, 0, 0), 1'b1, blank_scan});
    directed_plan.push_back('{make_item(OP_DIGIT, 0, 0, 0, 0, 0, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_DIGIT, 15, 14, 15, 1, 1, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_DIGIT, 5, DigitReject, 0, 1, 0, 0), 1'b1, rejected});
    directed_plan.push_back('{make_item(OP_POINT, 0, 0, 0, 0, 0, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_POINT, 15, 0, 0, 1, 0, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_BIT, 3, 0, 0, 0, 0, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_BIT, 3, 0, 15, 0, 0, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_BIT, 15, 0, 15, 1, 0, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_NUMBER, 0, 0, 0, 0, 0, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_NUMBER, 0, 0, 0, 0, 1, 0), 1'b1, none});
    directed_plan.push_back('{make_item(OP_NUMBER, 0, 0, 0, 0, 0, 999), 1'b1, none});
    directed_plan.push_back('{make_item(OP_NUMBER, 0, 0, 0, 0, 0, 1000), 1'b1, none});
    directed_plan.push_back('{make_item(OP_NUMBER, 0, 0, 0, 0, 1, 99999), 1'b1, none});
    directed_plan.push_back('{make_item(OP_NUMBER, 0, 0, 0, 0, 1, 131071), 1'b1, none});
    directed_plan.push_back('{make_item(OP_NUMBER, 0, 0, 0, 0, 0, 131071), 1'b1, none});
    directed_plan.push_back('{make_item(OpSpareFirst, 7, 15, 15, 1, 1, 131071), 1'b1, none});
    directed_plan.push_back('{make_item(OpSpareLast, 0, 0, 0, 0, 0, 0), 1'b1, none});
    // Scan the written words back; checked against the shadow state
    for (int i = 0; i < 7; i++)
      directed_plan.push_back('{make_item(OP_SCAN, 0, 0, 0, 0, 0, 0), 1'b0, none});

    // Hold reset, release on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i]) offer(directed_plan[i].item, directed_plan[i].fixed,
                                     directed_plan[i].want);

    for (int unsigned k = 0; k < RandomItems; k++) begin
      if (k == 100) hold_req = 1'b1;
      calm = (k >= 400 && k < 520);
      if (k == 600) begin
        // Pause the sender until every outstanding result has arrived
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      offer(random_item(), 1'b0, none);
    end
    in_valid <= 1'b0;

    // Drain, then allow a few more cycles for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
